// File: design/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared constants, widths and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam int FRAC_BITS = 16;

   localparam int REF_W  = 30;
   localparam int FREQ_W = 30;
   localparam int D_W    = 7;
   localparam int M8_W   = 11;
   localparam int O8_W   = 11;
   localparam int AF_W   = 46;
   localparam int DIV_W  = 30;

   localparam int NUM_W = REF_W + M8_W;          // ref * m8
   localparam int DEN_W = D_W + O8_W;            // d * o8, d * fb needs more
   localparam int DFB_W = D_W + FREQ_W;          // d * fb
   localparam int SN_W  = NUM_W + FRAC_BITS;     // num << FRAC_BITS
   localparam int ERR_W = 64;
   localparam int DV_W  = 64;                    // generic divider width
   localparam int DVC_W = 7;                     // divider step counter

   localparam logic [D_W-1:0]  D_MAX  = 7'd106;
   localparam logic [M8_W-1:0] M8_MIN = 11'd16;
   localparam logic [M8_W-1:0] M8_MAX = 11'd1024;
   localparam logic [O8_W-1:0] O8_MIN = 11'd8;
   localparam logic [O8_W-1:0] O8_MAX = 11'd1024;

   localparam logic [63:0] VCO_MIN_HZ = 64'd800000000;
   localparam logic [63:0] VCO_MAX_HZ = 64'd1600000000;
   localparam logic [63:0] PFD_MIN_HZ = 64'd10000000;
   localparam logic [63:0] PFD_MAX_HZ = 64'd500000000;
   localparam logic [63:0] OUT_MAX_HZ = 64'd775000000;
   localparam logic [ERR_W-1:0] TIE_TOL = ERR_W'((64'd1 << FRAC_BITS) / 1000);

   localparam logic [REF_W-1:0] REF_RESET = 30'd100000000;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,     // latch inputs, clear best
      OP_D_CHECK,   // evaluate d limits
      OP_D_NEXT,
      OP_M_INIT,
      OP_M_CHECK,
      OP_M_NEXT,
      OP_DIV_O,     // launch num / (d*fb)
      OP_SEL_FL,    // pick floor candidate
      OP_SEL_CE,
      OP_DIV_F,     // launch rounded frequency divide
      OP_UPDATE,    // compare and keep best
      OP_DIV_TICK,
      OP_DIV_TF,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic d_stop;     // d beyond range or pfd too low
      logic d_skip;
      logic m_below;
      logic m_above;    // vco too high or m8 past max
      logic o_ok;       // current candidate within o8 limits
      logic div_busy;
      logic has_ceil;   // ceiling differs from floor
      logic have;
   } sts_type;

endpackage

// File: design/pds_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64-bit quotient, one bit a cycle.
// ----------------------------------------------------------------------------
module pds_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pds_pkg::DV_W-1:0]  dividend,
   input  logic [pds_pkg::DV_W-1:0]  divisor,
   output logic                      busy,
   output logic [pds_pkg::DV_W-1:0]  quotient,
   output logic [pds_pkg::DV_W-1:0]  remainder
);
   import pds_pkg::*;

   logic [DV_W-1:0]  q_ff, q_in, r_ff, r_in, dv_ff, dv_in;
   logic [DVC_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DV_W:0]    trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff, q_ff[DV_W-1]};
      if (start) begin
         q_in = dividend; r_in = '0; dv_in = divisor;
         cnt_in = DVC_W'(DV_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract where it fits
         if (trial >= {1'b0, dv_ff}) begin
            r_in = DV_W'(trial - {1'b0, dv_ff});
            q_in = {q_ff[DV_W-2:0], 1'b1};
         end else begin
            r_in = trial[DV_W-1:0];
            q_in = {q_ff[DV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DVC_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;

   a_cnt : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> cnt_ff != '0) else $error("divider count lost");
endmodule

// File: design/pds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search datapath
// Candidate registers, limit compares, best-candidate store, shared divider.
// ----------------------------------------------------------------------------
module pds_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pds_pkg::cmd_type              cmd,
   output pds_pkg::sts_type              sts,
   input  logic [pds_pkg::REF_W-1:0]     ref_hz,
   input  logic [pds_pkg::FREQ_W-1:0]    base_hz,
   input  logic [pds_pkg::FREQ_W-1:0]    isr_hz,
   output logic [pds_pkg::D_W-1:0]       best_d,
   output logic [pds_pkg::M8_W-1:0]      best_m,
   output logic [pds_pkg::O8_W-1:0]      best_o,
   output logic [pds_pkg::AF_W-1:0]      best_f,
   output logic [pds_pkg::DIV_W-1:0]     tick_div,
   output logic [pds_pkg::AF_W-1:0]      tick_f
);
   import pds_pkg::*;

   logic [REF_W-1:0]  fref_ff, fref_in;
   logic [FREQ_W-1:0] fb_ff, fb_in, fi_ff, fi_in;
   logic [D_W:0]      d_ff, d_in;
   logic [M8_W-1:0]   m_ff, m_in;
   logic [DV_W-1:0]   fl_ff, fl_in;
   logic              ce_ff, ce_in;
   logic [DV_W-1:0]   o_ff, o_in;
   logic [D_W-1:0]    bd_ff, bd_in;
   logic [M8_W-1:0]   bm_ff, bm_in;
   logic [O8_W-1:0]   bo_ff, bo_in;
   logic [AF_W-1:0]   bf_ff, bf_in, tf_ff, tf_in;
   logic [ERR_W-1:0]  be_ff, be_in;
   logic              bint_ff, bint_in, have_ff, have_in;
   logic [DIV_W-1:0]  td_ff, td_in;
   logic [NUM_W-1:0]  num_ff, num_in;

   logic              dv_start;
   logic [DV_W-1:0]   dv_a, dv_b, dv_q, dv_r;
   logic              dv_busy;

   pds_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_a),
      .divisor(dv_b), .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
   );

   logic [63:0] d64, lim64, dd64, f64, tgt64, err64, diff64, den64;
   logic        integ, take;

   always_comb begin
      d64   = 64'(d_ff);
      lim64 = d64 << 3;
      dd64  = d64 * 64'(o_ff[O8_W-1:0]);
      f64   = dv_q;
      tgt64 = 64'(fb_ff) << FRAC_BITS;
      err64 = (f64 > tgt64) ? f64 - tgt64 : tgt64 - f64;
      diff64 = (err64 > be_ff) ? err64 - be_ff : be_ff - err64;
      integ = (m_ff[2:0] == 3'd0) && (o_ff[2:0] == 3'd0);
      take  = !have_ff || (err64 + TIE_TOL < be_ff) ||
              (diff64 <= TIE_TOL && integ && !bint_ff);
      den64 = (fi_ff == '0) ? (64'd1 << FRAC_BITS) : (64'(fi_ff) << FRAC_BITS);

      sts.d_stop   = (d_ff > 8'(D_MAX)) || (64'(fref_ff) < PFD_MIN_HZ * d64);
      sts.d_skip   = 64'(fref_ff) > PFD_MAX_HZ * d64;
      sts.m_below  = 64'(num_ff) < VCO_MIN_HZ * lim64;
      sts.m_above  = (m_ff > M8_MAX) || (64'(num_ff) > VCO_MAX_HZ * lim64);
      sts.o_ok     = (o_ff >= 64'(O8_MIN)) && (o_ff <= 64'(O8_MAX));
      sts.div_busy = dv_busy;
      sts.has_ceil = ce_ff;
      sts.have     = have_ff;
   end

   always_comb begin
      fref_in = fref_ff; fb_in = fb_ff; fi_in = fi_ff; d_in = d_ff; m_in = m_ff;
      fl_in = fl_ff; ce_in = ce_ff; o_in = o_ff; bd_in = bd_ff; bm_in = bm_ff;
      bo_in = bo_ff; bf_in = bf_ff; be_in = be_ff; bint_in = bint_ff;
      have_in = have_ff; td_in = td_ff; tf_in = tf_ff; num_in = num_ff;
      dv_start = 1'b0; dv_a = '0; dv_b = '0;
      case (cmd.op)
         OP_START: begin
            fref_in = ref_hz; fb_in = base_hz; fi_in = isr_hz;
            d_in = 8'd1; have_in = 1'b0; bint_in = 1'b0; be_in = '0;
            bd_in = '0; bm_in = '0; bo_in = '0; bf_in = '0; td_in = '0; tf_in = '0;
         end
         OP_D_NEXT:  d_in = d_ff + 1'b1;
         OP_M_INIT: begin
            m_in = M8_MIN;
            num_in = NUM_W'(fref_ff) * NUM_W'(M8_MIN);
         end
         OP_M_NEXT: begin
            m_in = m_ff + 1'b1;
            num_in = NUM_W'(fref_ff) * NUM_W'(m_ff + 1'b1);
         end
         OP_DIV_O: begin
            dv_start = 1'b1; dv_a = 64'(num_ff); dv_b = d64 * 64'(fb_ff);
         end
         OP_SEL_FL: begin
            fl_in = dv_q; ce_in = (dv_r != '0); o_in = dv_q;
         end
         OP_SEL_CE:  o_in = fl_ff + 64'd1;
         OP_DIV_F: begin
            // rounded half up: (num << F + dd/2) / dd
            dv_start = 1'b1;
            dv_a = (64'(num_ff) << FRAC_BITS) + (dd64 >> 1);
            dv_b = dd64;
         end
         OP_UPDATE: begin
            if (take) begin
               have_in = 1'b1; be_in = err64; bint_in = integ;
               bd_in = d_ff[D_W-1:0]; bm_in = m_ff; bo_in = o_ff[O8_W-1:0];
               bf_in = AF_W'(f64);
            end
         end
         OP_DIV_TICK: begin
            dv_start = 1'b1;
            dv_a = (64'(bf_ff) << 1) + den64;
            dv_b = den64 << 1;
         end
         OP_DIV_TF: begin
            if (64'(bf_ff) < den64 || dv_q == '0) td_in = DIV_W'(1);
            else if (dv_q > 64'h3FFF_FFFF)        td_in = '1;
            else                                  td_in = dv_q[DIV_W-1:0];
            dv_start = 1'b1;
            if (64'(bf_ff) < den64 || dv_q == '0) begin
               dv_a = 64'(bf_ff); dv_b = 64'd1;
            end else if (dv_q > 64'h3FFF_FFFF) begin
               dv_a = 64'(bf_ff) + 64'h1FFF_FFFF; dv_b = 64'h3FFF_FFFF;
            end else begin
               dv_a = 64'(bf_ff) + (dv_q >> 1); dv_b = dv_q;
            end
         end
         OP_FINISH:  tf_in = AF_W'(dv_q);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      fref_ff <= fref_in; fb_ff <= fb_in; fi_ff <= fi_in; d_ff <= d_in;
      m_ff <= m_in; fl_ff <= fl_in; ce_ff <= ce_in; o_ff <= o_in;
      bd_ff <= bd_in; bm_ff <= bm_in; bo_ff <= bo_in; bf_ff <= bf_in;
      be_ff <= be_in; bint_ff <= bint_in; td_ff <= td_in; tf_ff <= tf_in;
      num_ff <= num_in;
      if (reset) have_ff <= 1'b0;
      else       have_ff <= have_in;
   end

   assign best_d = bd_ff;
   assign best_m = bm_ff;
   assign best_o = bo_ff;
   assign best_f = bf_ff;
   assign tick_div = td_ff;
   assign tick_f = tf_ff;

   a_best : assert property (@(posedge clock) disable iff (reset)
      have_ff |-> bd_ff != '0 && bo_ff >= O8_MIN) else $error("best setting illegal");
   a_upd : assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UPDATE |=> have_ff) else $error("update kept nothing");
   a_dv : assert property (@(posedge clock) disable iff (reset)
      dv_start |=> dv_busy) else $error("divider did not start");
endmodule

// File: design/pds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search controller
// Sequences the D, M and floor/ceiling loops and the final tick divides.
// ----------------------------------------------------------------------------
module pds_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             base_ok,
   output logic             idle,
   output logic             done,
   output pds_pkg::cmd_type cmd,
   input  pds_pkg::sts_type sts
);
   import pds_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DCHK = 4'd1, S_MINIT = 4'd2,
      S_MCHK = 4'd3, S_ODIV = 4'd4, S_OWAIT = 4'd5, S_FL = 4'd6, S_FWAIT = 4'd7,
      S_UPD = 4'd8, S_CE = 4'd9, S_TICK = 4'd10, S_TWAIT = 4'd11, S_TFWAIT = 4'd12,
      S_DONE = 4'd13, S_MNEXT = 4'd14, S_DNEXT = 4'd15;

   logic [3:0] st_ff, st_in;
   logic       ce_ff, ce_in;

   always_comb begin
      st_in = st_ff; ce_in = ce_ff; cmd.op = OP_NONE; done = 1'b0;
      case (st_ff)
         S_IDLE: if (start) begin
            cmd.op = OP_START;
            st_in = base_ok ? S_DCHK : S_DONE;
         end
         S_DCHK: begin
            if (sts.d_stop)      st_in = sts.have ? S_TICK : S_DONE;
            else if (sts.d_skip) st_in = S_DNEXT;
            else                 st_in = S_MINIT;
         end
         S_DNEXT: begin cmd.op = OP_D_NEXT; st_in = S_DCHK; end
         S_MINIT: begin cmd.op = OP_M_INIT; st_in = S_MCHK; end
         S_MCHK: begin
            if (sts.m_above)      st_in = S_DNEXT;
            else if (sts.m_below) st_in = S_MNEXT;
            else                  st_in = S_ODIV;
         end
         S_MNEXT: begin cmd.op = OP_M_NEXT; st_in = S_MCHK; end
         S_ODIV: begin cmd.op = OP_DIV_O; st_in = S_OWAIT; end
         S_OWAIT: if (!sts.div_busy) begin
            cmd.op = OP_SEL_FL; ce_in = 1'b0; st_in = S_FL;
         end
         S_FL: begin
            if (sts.o_ok) begin cmd.op = OP_DIV_F; st_in = S_FWAIT; end
            else          st_in = S_CE;
         end
         S_FWAIT: if (!sts.div_busy) st_in = S_UPD;
         S_UPD: begin cmd.op = OP_UPDATE; st_in = S_CE; end
         S_CE: begin
            if (!ce_ff && sts.has_ceil) begin
               cmd.op = OP_SEL_CE; ce_in = 1'b1; st_in = S_FL;
            end else st_in = S_MNEXT;
         end
         S_TICK: begin cmd.op = OP_DIV_TICK; st_in = S_TWAIT; end
         S_TWAIT: if (!sts.div_busy) begin cmd.op = OP_DIV_TF; st_in = S_TFWAIT; end
         S_TFWAIT: if (!sts.div_busy) begin cmd.op = OP_FINISH; st_in = S_DONE; end
         S_DONE: begin done = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ce_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ce_ff <= ce_in;
      end
   end

   assign idle = (st_ff == S_IDLE);

   a_done : assert property (@(posedge clock) disable iff (reset)
      done |=> idle) else $error("done not followed by idle");
   a_start : assert property (@(posedge clock) disable iff (reset)
      !idle |-> cmd.op != OP_START) else $error("start while busy");
   a_upd : assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UPDATE |-> $past(st_ff) == S_FWAIT) else $error("update out of order");
endmodule

// File: design/pll_divider_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search core
// Finds D, M and O for a wanted output frequency and a tick divider.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  req_     in   tdata: target_base_hz[29:0], target_isr_hz[59:30]
//  rsp_     out  tdata: input_divide, feedback_mult_eighths, output_divide_eighths,
//                achieved_base_freq, tick_divider, achieved_tick_freq; tuser: found
//  csr_     in   reference_freq_hz
//
// One request at a time. Each (D, M) pair in the VCO window takes a floor
// divide and up to two frequency divides, all in the one shared 64-bit
// bit-serial divider. Reset is synchronous and drops any search. A result
// waiting in the output register stalls the next search only.
// ----------------------------------------------------------------------------
module pll_divider_search_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // target_base_hz, target_isr_hz, zero fill
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,   // input_divide, feedback_mult_eighths,
                                      // output_divide_eighths, achieved_base_freq,
                                      // tick_divider, achieved_tick_freq, zero fill
   output logic          rsp_tuser,   // found
   input  logic          csr_we,
   input  logic [29:0]   csr_wdata
);
   import pds_pkg::*;

   logic [REF_W-1:0] ref_ff, ref_in;
   logic             idle, done, start, base_ok;
   cmd_type          cmd;
   sts_type          sts;
   logic [D_W-1:0]   bd;
   logic [M8_W-1:0]  bm;
   logic [O8_W-1:0]  bo;
   logic [AF_W-1:0]  bf, tf;
   logic [DIV_W-1:0] td;
   logic             vld_ff, vld_in, fnd_ff, fnd_in;
   logic [151:0]     dat_ff, dat_in;

   assign ref_in = csr_we ? csr_wdata : ref_ff;
   assign req_tready = idle && !vld_ff;
   assign start = req_tvalid && req_tready;
   assign base_ok = (req_tdata[29:0] != '0) && (64'(req_tdata[29:0]) <= OUT_MAX_HZ);

   pds_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .base_ok(base_ok),
      .idle(idle), .done(done), .cmd(cmd), .sts(sts)
   );

   pds_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .ref_hz(ref_ff),
      .base_hz(req_tdata[29:0]), .isr_hz(req_tdata[59:30]),
      .best_d(bd), .best_m(bm), .best_o(bo), .best_f(bf), .tick_div(td), .tick_f(tf)
   );

   always_comb begin
      vld_in = vld_ff; fnd_in = fnd_ff; dat_in = dat_ff;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      if (done) begin
         vld_in = 1'b1;
         fnd_in = sts.have;
         dat_in = sts.have ? {1'b0, tf, td, bf, bo, bm, bd} : '0;
      end
   end

   always_ff @(posedge clock) begin
      dat_ff <= dat_in; fnd_ff <= fnd_in;
      if (reset) begin
         vld_ff <= 1'b0; ref_ff <= REF_RESET;
      end else begin
         vld_ff <= vld_in; ref_ff <= ref_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = dat_ff;
   assign rsp_tuser = fnd_ff;

   a_hold : assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_tready |=> vld_ff) else $error("result dropped");
   a_nostart : assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> !start) else $error("search started over waiting result");
   a_found : assert property (@(posedge clock) disable iff (reset)
      vld_ff && fnd_ff |-> dat_ff[6:0] != '0) else $error("found without divider");
endmodule
